/* hw/rtl/slhb_pkg.sv */
package slhb_pkg;

    localparam int HEAD_CHARS = 5;
    localparam int HEAD_IDX_W = $clog2(HEAD_CHARS);
    localparam int LEN_W      = 4;
    localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_RX   = 2'd1;
    localparam logic [1:0] ACT_SEND = 2'd2;

    localparam logic [1:0] TRIP_NONE  = 2'd0;
    localparam logic [1:0] TRIP_PORT  = 2'd1;
    localparam logic [1:0] TRIP_ESTOP = 2'd2;
    localparam logic [1:0] TRIP_WRONG = 2'd3;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [7:0] LIMIT_RESET = 8'd10;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    typedef struct packed {
        logic [1:0] action;
        logic       heartbeat_level;
        logic       tripped;
        logic       port_fault;
        logic [7:0] rx_byte;
        logic [7:0] command_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] trip_request;
        logic       send_accepted;
        logic       ack_waiting;
        logic [7:0] wrong_ack_total;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t    first;
        result_t    second;
        logic [1:0] count;
    } result_pair_t;

endpackage

/* hw/rtl/slhb_in.sv */
module slhb_in
    import slhb_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

/* hw/rtl/slhb_core.sv */
module slhb_core
    import slhb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_data,
    input  logic         fire,
    input  item_t        item,
    output result_pair_t res
);

    logic [7:0]       limit_reg;
    logic [7:0]       pend_char_reg, pend_char_next;
    logic             pend_reg, pend_next;
    logic             link_reg, link_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       wrong_reg, wrong_next;
    logic [7:0]       line_head_reg [HEAD_CHARS];

    logic                  head_we;
    logic [HEAD_IDX_W-1:0] head_idx;
    logic                  is_ack, is_estop, ack_match;
    logic [1:0]            trip;
    logic [7:0]            hb_char;
    logic                  send_hb, send_e, send_cmd;

    assign head_idx = len_reg[HEAD_IDX_W-1:0];

    assign is_ack = (len_reg >= LEN_W'(3)) && line_head_reg[0] == CH_A
                    && line_head_reg[1] == CH_C && line_head_reg[2] == CH_K;
    assign is_estop = (len_reg >= LEN_W'(5)) && line_head_reg[0] == CH_E
                    && line_head_reg[1] == CH_S && line_head_reg[2] == CH_T
                    && line_head_reg[3] == CH_O && line_head_reg[4] == CH_P;
    assign ack_match = pend_reg && len_reg == LEN_W'(5)
                    && line_head_reg[3] == CH_SPACE && line_head_reg[4] == pend_char_reg;
    assign hb_char = item.heartbeat_level ? CH_PLUS : CH_MINUS;

    always_comb begin
        pend_char_next = pend_char_reg;
        pend_next      = pend_reg;
        link_next      = link_reg;
        len_next       = len_reg;
        wrong_next     = wrong_reg;
        head_we        = 1'b0;
        trip           = TRIP_NONE;
        send_hb        = 1'b0;
        send_e         = 1'b0;
        send_cmd       = 1'b0;

        unique case (item.action)
            ACT_TICK: begin
                if (link_reg) begin
                    if (!pend_reg) begin
                        send_hb        = 1'b1;
                        send_e         = item.tripped;
                        pend_char_next = item.tripped ? CH_E : hb_char;
                        pend_next      = 1'b1;
                    end
                    if (item.port_fault) begin
                        link_next = 1'b0;
                        trip      = TRIP_PORT;
                    end
                end
                if (trip == TRIP_NONE && wrong_reg > limit_reg && !item.tripped) begin
                    trip = TRIP_WRONG;
                end
            end
            ACT_RX: begin
                if (item.rx_byte == CH_NEWLINE) begin
                    if (is_ack) begin
                        if (ack_match) begin
                            pend_next = 1'b0;
                        end else if (wrong_reg != COUNT_MAX) begin
                            wrong_next = wrong_reg + 8'd1;
                        end
                    end else if (is_estop) begin
                        trip = TRIP_ESTOP;
                    end
                    len_next = '0;
                end else begin
                    head_we = len_reg < LEN_W'(HEAD_CHARS);
                    if (len_reg != LEN_MAX) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
            ACT_SEND: begin
                if (link_reg && !pend_reg) begin
                    send_cmd       = 1'b1;
                    pend_char_next = item.command_byte;
                    pend_next      = 1'b1;
                end else if (pend_reg && wrong_reg != COUNT_MAX) begin
                    wrong_next = wrong_reg + 8'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Both results carry the state as it stands after this request.
    always_comb begin
        res.first                 = '0;
        res.first.ack_waiting     = pend_next;
        res.first.wrong_ack_total = wrong_next;
        res.second                = res.first;
        res.count                 = 2'd1;
        if (send_e) begin
            res.first.tx_valid      = 1'b1;
            res.first.tx_byte       = hb_char;
            res.second.tx_valid     = 1'b1;
            res.second.tx_byte      = CH_E;
            res.second.trip_request = trip;
            res.second.last         = 1'b1;
            res.count               = 2'd2;
        end else begin
            res.first.tx_valid      = send_hb || send_cmd;
            res.first.tx_byte       = send_cmd ? item.command_byte
                                    : (send_hb ? hb_char : 8'd0);
            res.first.trip_request  = trip;
            res.first.send_accepted = send_cmd;
            res.first.last          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RESET;
            pend_char_reg <= '0;
            pend_reg      <= 1'b0;
            link_reg      <= 1'b1;
            len_reg       <= '0;
            wrong_reg     <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
            if (fire) begin
                pend_char_reg <= pend_char_next;
                pend_reg      <= pend_next;
                link_reg      <= link_next;
                len_reg       <= len_next;
                wrong_reg     <= wrong_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && head_we) begin
            line_head_reg[head_idx] <= item.rx_byte;
        end
    end

endmodule

/* hw/rtl/slhb_out.sv */
module slhb_out
    import slhb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load_valid,
    output logic         load_ready,
    input  result_pair_t load,
    output logic         m_valid,
    input  logic         m_ready,
    output result_t      m_res
);

    logic [1:0] count_reg;
    result_t    head_reg, tail_reg;
    logic       pop;

    assign m_valid    = count_reg != 2'd0;
    assign m_res      = head_reg;
    assign pop        = m_valid && m_ready;
    // A new pair may land once the buffer drains this cycle.
    assign load_ready = count_reg == 2'd0 || (count_reg == 2'd1 && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load_valid && load_ready) begin
            count_reg <= load.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            head_reg <= load.first;
            tail_reg <= load.second;
        end else if (pop) begin
            head_reg <= tail_reg;
        end
    end

endmodule

/* hw/rtl/safety_link_heartbeat_ack_checker.sv */
// Safety-link heartbeat and acknowledge checker. Requests enter on s_, are
// registered, evaluated in one pass against the link state and handed to a
// two-entry result buffer; m_last marks the final result of each request. A
// new request is taken every cycle while results drain; a tick that sends the
// heartbeat together with 'E' yields two results on the output port, every
// other request one. An accepted request passes the input register and then the
// result buffer before its first result is on m_. The wrong-acknowledge limit
// (cfg_data, reset 10) is to be written only while no request is in flight.
module safety_link_heartbeat_ack_checker
    import slhb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic       s_heartbeat_level,
    input  logic       s_tripped,
    input  logic       s_port_fault,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_command_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic [1:0] m_trip_request,
    output logic       m_send_accepted,
    output logic       m_ack_waiting,
    output logic [7:0] m_wrong_ack_total,
    output logic       m_last
);

    item_t        s_item, item;
    logic         item_valid, load_ready, fire;
    result_pair_t pair;
    result_t      m_res;

    assign cfg_ready = 1'b1;
    assign fire      = item_valid && load_ready;

    assign s_item.action          = s_action;
    assign s_item.heartbeat_level = s_heartbeat_level;
    assign s_item.tripped         = s_tripped;
    assign s_item.port_fault      = s_port_fault;
    assign s_item.rx_byte         = s_rx_byte;
    assign s_item.command_byte    = s_command_byte;

    slhb_in u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (load_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    slhb_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item),
        .res      (pair)
    );

    slhb_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (item_valid),
        .load_ready (load_ready),
        .load       (pair),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_tx_valid        = m_res.tx_valid;
    assign m_tx_byte         = m_res.tx_byte;
    assign m_trip_request    = m_res.trip_request;
    assign m_send_accepted   = m_res.send_accepted;
    assign m_ack_waiting     = m_res.ack_waiting;
    assign m_wrong_ack_total = m_res.wrong_ack_total;
    assign m_last            = m_res.last;

endmodule

/* hw/rtl/slhb_checker.sv */
module slhb_checker
    import slhb_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic [1:0] m_trip_request,
    input logic       m_send_accepted,
    input logic       m_ack_waiting,
    input logic       m_last
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_last))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The only two-result request is heartbeat then 'E'; the first carries no trip.
    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_tx_valid && m_trip_request == TRIP_NONE
                               && !m_send_accepted)
        else $error("bad first result of a pair");

    a_idle_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_byte == 8'd0 && !m_send_accepted)
        else $error("byte without transmit");

    a_send_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_send_accepted || m_tx_valid) |-> m_ack_waiting)
        else $error("transmit without pending acknowledge");

endmodule

bind safety_link_heartbeat_ack_checker slhb_checker u_slhb_checker (.*);
